[rtl/core/xkbc_pkg.sv]
// Shared constants, types and functions for the xorshift keyed byte cipher.
package xkbc_pkg;

    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 5;

    localparam int unsigned STATE_W = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OP_W    = 2;

    localparam logic [STATE_W-1:0] SEED_RESET = 32'd1;
    localparam logic [BYTE_W-1:0]  KEY_ZERO_SUB = 8'd1;

    typedef enum logic [0:0] {
        CFG_SEED      = 1'b0,
        CFG_DIRECTION = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } dir_t;

    typedef enum logic [OP_W-1:0] {
        OP_XOR     = 2'd0,
        OP_ADD_SUB = 2'd1,
        OP_SUB_ADD = 2'd2
    } op_t;

    typedef struct packed {
        logic fire;
        logic start;
        logic term;
    } keygen_ctrl_t;

    typedef struct packed {
        logic [BYTE_W-1:0] key;
        op_t               op;
    } keystream_t;

    function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] t;
        t = s ^ (s << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

    // 4 == 1 (mod 3): sum the base-4 digits, then fold down.
    function automatic logic [1:0] mod3(input logic [STATE_W-1:0] v);
        logic [2:0] pair;
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        s1 = '0;
        for (int i = 0; i < STATE_W / 4; i++) begin
            pair = {1'b0, v[4*i +: 2]} + {1'b0, v[4*i+2 +: 2]};
            s1   = s1 + {3'b000, pair};
        end
        s2 = {2'b00, s1[1:0]} + {2'b00, s1[3:2]} + {2'b00, s1[5:4]};
        s3 = {1'b0, s2[1:0]} + {1'b0, s2[3:2]};
        if (s3 >= 3'd3) begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

endpackage

[rtl/core/xorshift_keyed_byte_cipher.sv]
// Top level: xorshift keyed byte cipher with input and output item registers.
//
//   channel   dir   handshake           payload
//   s_        in    s_tvalid/s_tready   tdata: data_in; tuser: start_req, is_terminator
//   m_        out   m_tvalid/m_tready   tdata: data_out; tuser: op_used
//   cfg_      in    cfg_wr_en           cfg_index, cfg_wdata (seed, direction)
//
// One item per clock while m_tready is high; m_tvalid rises when the output register
// takes the item from the input register. The cycle is set by the two chained xorshift
// rounds plus the mod-3 fold and byte op, all between the input and output registers.
// Synchronous active-low reset: seed 1, encrypt, generator state 1.
// A stall on m_ holds the output register; s_tready stays high while the
// input register can move on, so both stages stay full under backpressure.
module xorshift_keyed_byte_cipher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic [1:0]  s_tuser,   // [0] start_req, [1] is_terminator
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    output logic [1:0]  m_tuser,   // [1:0] op_used
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [xkbc_pkg::STATE_W-1:0] seed_reg;
    xkbc_pkg::dir_t               dir_reg;

    logic                         in_valid_reg;
    logic [xkbc_pkg::BYTE_W-1:0]  in_data_reg;
    logic                         in_start_reg;
    logic                         in_term_reg;

    logic                         out_valid_reg;
    logic [xkbc_pkg::BYTE_W-1:0]  out_data_reg;
    xkbc_pkg::op_t                out_op_reg;

    logic                         out_free;
    logic                         fire;
    xkbc_pkg::keygen_ctrl_t       kg_ctrl;
    xkbc_pkg::keystream_t         ks;
    logic [xkbc_pkg::BYTE_W-1:0]  res_data;
    xkbc_pkg::op_t                res_op;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign kg_ctrl.fire  = fire;
    assign kg_ctrl.start = in_start_reg;
    assign kg_ctrl.term  = in_term_reg;

    xkbc_keygen u_keygen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (kg_ctrl),
        .seed    (seed_reg),
        .ks      (ks)
    );

    xkbc_byte_op u_byte_op (
        .data_in       (in_data_reg),
        .is_terminator (in_term_reg),
        .direction     (dir_reg),
        .ks            (ks),
        .data_out      (res_data),
        .op_used       (res_op)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= xkbc_pkg::SEED_RESET;
            dir_reg  <= xkbc_pkg::DIR_ENCRYPT;
        end else if (cfg_wr_en) begin
            case (xkbc_pkg::cfg_index_t'(cfg_index))
                xkbc_pkg::CFG_SEED: begin
                    seed_reg <= cfg_wdata;
                end
                xkbc_pkg::CFG_DIRECTION: begin
                    dir_reg <= xkbc_pkg::dir_t'(cfg_wdata[0]);
                end
                default: begin
                    seed_reg <= seed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
            in_term_reg  <= s_tuser[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= res_data;
            out_op_reg   <= res_op;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_op_reg;

endmodule

[rtl/core/xkbc_keygen.sv]
// Keystream generator: xorshift state register, two rounds per payload item.
module xkbc_keygen (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  xkbc_pkg::keygen_ctrl_t        ctrl,
    input  logic [xkbc_pkg::STATE_W-1:0]  seed,
    output xkbc_pkg::keystream_t          ks
);

    logic [xkbc_pkg::STATE_W-1:0] state_reg;
    logic [xkbc_pkg::STATE_W-1:0] state_next;
    logic [xkbc_pkg::STATE_W-1:0] base;
    logic [xkbc_pkg::STATE_W-1:0] round1;
    logic [xkbc_pkg::STATE_W-1:0] round2;

    assign base   = ctrl.start ? seed : state_reg;
    assign round1 = xkbc_pkg::advance(base);
    assign round2 = xkbc_pkg::advance(round1);

    always_comb begin
        ks.key = round1[xkbc_pkg::BYTE_W-1:0];
        if (ks.key == '0) begin
            ks.key = xkbc_pkg::KEY_ZERO_SUB;
        end
        ks.op = xkbc_pkg::op_t'(xkbc_pkg::mod3(round2));
    end

    always_comb begin
        state_next = state_reg;
        if (ctrl.fire) begin
            state_next = ctrl.term ? base : round2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= xkbc_pkg::SEED_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/xkbc_byte_op.sv]
// Byte transform: xor, add or subtract the key, or pass a terminator through.
module xkbc_byte_op (
    input  logic [xkbc_pkg::BYTE_W-1:0] data_in,
    input  logic                        is_terminator,
    input  xkbc_pkg::dir_t              direction,
    input  xkbc_pkg::keystream_t        ks,
    output logic [xkbc_pkg::BYTE_W-1:0] data_out,
    output xkbc_pkg::op_t               op_used
);

    logic add_sel;

    always_comb begin
        add_sel  = 1'b0;
        data_out = data_in;
        op_used  = xkbc_pkg::OP_XOR;
        if (!is_terminator) begin
            op_used = ks.op;
            case (ks.op)
                xkbc_pkg::OP_XOR: begin
                    data_out = data_in ^ ks.key;
                end
                xkbc_pkg::OP_ADD_SUB: begin
                    add_sel  = (direction == xkbc_pkg::DIR_ENCRYPT);
                    data_out = add_sel ? data_in + ks.key : data_in - ks.key;
                end
                xkbc_pkg::OP_SUB_ADD: begin
                    add_sel  = (direction == xkbc_pkg::DIR_DECRYPT);
                    data_out = add_sel ? data_in + ks.key : data_in - ks.key;
                end
                default: begin
                    data_out = data_in;
                end
            endcase
        end
    end

endmodule

[tb/sv/xorshift_keyed_byte_cipher_tb.sv]
// Testbench for the xorshift keyed byte cipher: directed and random streams checked per item.
module xorshift_keyed_byte_cipher_tb;

    typedef struct {
        logic [7:0]     data;
        xkbc_pkg::op_t  op;
    } cipher_byte_t;

    class cipher_byte_tracker;
        logic [31:0]     seed_reg;
        xkbc_pkg::dir_t  dir_reg;
        logic [31:0]     gen_state;
        cipher_byte_t    expected_bytes[$];
        int              fails;

        function new();
            seed_reg  = 32'd1;
            dir_reg   = xkbc_pkg::DIR_ENCRYPT;
            gen_state = 32'd1;
            fails     = 0;
        endfunction

        function void set_cfg(xkbc_pkg::cfg_index_t idx, logic [31:0] value);
            if (idx == xkbc_pkg::CFG_SEED) begin
                seed_reg = value;
            end else begin
                dir_reg = xkbc_pkg::dir_t'(value[0]);
            end
        endfunction

        function logic [31:0] xs_next(logic [31:0] s);
            logic [31:0] t;
            t = s ^ (s << 13);
            t = t ^ (t >> 17);
            t = t ^ (t << 5);
            return t;
        endfunction

        // predict the cipher output of one accepted item
        function void note_item(logic [7:0] din, logic start, logic term);
            cipher_byte_t exp_b;
            logic [7:0]   key;
            if (start) begin
                gen_state = seed_reg;
            end
            if (term) begin
                exp_b.data = din;
                exp_b.op   = xkbc_pkg::OP_XOR;
            end else begin
                gen_state = xs_next(gen_state);
                key = gen_state[7:0];
                if (key == 8'd0) begin
                    key = 8'd1;
                end
                gen_state = xs_next(gen_state);
                exp_b.op = xkbc_pkg::op_t'(2'(gen_state % 32'd3));
                case (exp_b.op)
                    xkbc_pkg::OP_XOR: begin
                        exp_b.data = din ^ key;
                    end
                    xkbc_pkg::OP_ADD_SUB: begin
                        exp_b.data = (dir_reg == xkbc_pkg::DIR_ENCRYPT) ? din + key : din - key;
                    end
                    default: begin
                        exp_b.data = (dir_reg == xkbc_pkg::DIR_ENCRYPT) ? din - key : din + key;
                    end
                endcase
            end
            expected_bytes = {expected_bytes, exp_b};
        endfunction

        function void check_item(logic [7:0] dout, logic [1:0] op);
            cipher_byte_t exp_b;
            if (expected_bytes.size() == 0) begin
                $error("unexpected item: data_out %0h op_used %0d", dout, op);
                fails++;
                return;
            end
            exp_b = expected_bytes.pop_front();
            if (dout !== exp_b.data) begin
                $error("data_out mismatch: expected %0h actual %0h", exp_b.data, dout);
                fails++;
            end
            if (op !== exp_b.op) begin
                $error("op_used mismatch: expected %0d actual %0d", exp_b.op, op);
                fails++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void close();
            if (expected_bytes.size() != 0) begin
                $error("%0d expected items never arrived", expected_bytes.size());
                fails++;
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic [1:0]  s_tuser   = 2'd0;   // [0] start_req, [1] is_terminator
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] data_out
    logic [1:0]  m_tuser;            // [1:0] op_used
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;

    cipher_byte_tracker tracker = new();
    bit src_idle = 1'b1;
    bit snk_idle = 1'b1;

    xorshift_keyed_byte_cipher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.note_item(s_tdata, s_tuser[0], s_tuser[1]);
            end
            if (m_tvalid && m_tready) begin
                tracker.check_item(m_tdata, m_tuser);
            end
        end
    end

    // output backpressure in bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left != 0) begin
                stall_left--;
            end else if (snk_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] din, input logic start, input logic term);
        int gap;
        if (src_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= din;
        s_tuser  <= {term, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input xkbc_pkg::cfg_index_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_cfg(idx, value);
        @(posedge aclk);
    endtask

    // mostly start-led messages, some noise and restarts mid-message
    task automatic run_messages(input int count);
        int  n;
        int  len;
        logic st;
        logic tm;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                n++;
            end else begin
                len = $urandom_range(1, 16);
                for (int i = 0; i < len && n < count; i++) begin
                    st = (i == 0) || ($urandom_range(0, 24) == 0);
                    tm = ((i == len - 1) && $urandom_range(0, 1) == 1) ||
                         ($urandom_range(0, 29) == 0);
                    send_byte(8'($urandom_range(0, 255)), st, tm);
                    n++;
                end
            end
        end
    endtask

    initial begin
        logic [31:0] seed_val;
        int          wait_cnt;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration, generator running from reset state
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'h77, 1'b1, 1'b1);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        drain();

        // decrypt, all-ones seed
        write_cfg(xkbc_pkg::CFG_SEED, 32'hFFFF_FFFF);
        write_cfg(xkbc_pkg::CFG_DIRECTION, {31'h7FFF_FFFF, xkbc_pkg::DIR_DECRYPT});
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'h56, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        drain();

        // zero seed: key stuck at 1, xor only
        write_cfg(xkbc_pkg::CFG_SEED, 32'd0);
        write_cfg(xkbc_pkg::CFG_DIRECTION, {31'd0, xkbc_pkg::DIR_ENCRYPT});
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h10, 1'b0, 1'b0);
        send_byte(8'h20, 1'b0, 1'b1);
        send_byte(8'h7E, 1'b0, 1'b0);

        for (int p = 0; p < 10; p++) begin
            drain();
            case (p)
                0: seed_val = 32'd1;
                1: seed_val = 32'hFFFF_FFFF;
                2: seed_val = 32'd0;
                3: seed_val = 32'h8000_0000;
                default: seed_val = $urandom();
            endcase
            write_cfg(xkbc_pkg::CFG_SEED, seed_val);
            write_cfg(xkbc_pkg::CFG_DIRECTION, $urandom());
            src_idle = (p < 8) && ($urandom_range(0, 3) != 0);
            snk_idle = (p < 8) && ($urandom_range(0, 3) != 0);
            run_messages(55);
        end

        s_tvalid <= 1'b0;
        src_idle = 1'b0;
        snk_idle = 1'b0;
        wait_cnt = 0;
        while (tracker.pending() != 0 && wait_cnt < 2000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (10) @(posedge aclk);
        tracker.close();
        if (tracker.fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
